// ----- hw/rtl/perlin_gradient_noise_2d_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the 2D gradient noise unit
// Shared forms for clocked implication checks with an async active-low reset.
// ----------------------------------------------------------------------------
`ifndef PERLIN_GRADIENT_NOISE_2D_UNIT_ASSERT_SVH
`define PERLIN_GRADIENT_NOISE_2D_UNIT_ASSERT_SVH

// same-cycle implication
`define PGN_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("pgn check failed");

// next-cycle implication
`define PGN_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("pgn check failed");

`endif

// ----- hw/rtl/pgn_pkg.sv -----
// ----------------------------------------------------------------------------
// pgn_pkg
// Types, hash constants and the quarter-wave sine used by the noise unit.
// ----------------------------------------------------------------------------
package pgn_pkg;

	localparam logic [31:0] HASH_K1 = 32'd3284157443;
	localparam logic [31:0] HASH_K2 = 32'd1911520717;
	localparam logic [31:0] HASH_K3 = 32'd2048419325;

	localparam logic [63:0] SIN_C1 = 64'd1686629713;
	localparam logic [63:0] SIN_C3 = 64'd693598661;
	localparam logic [63:0] SIN_C5 = 64'd85569307;
	localparam logic [63:0] SIN_C7 = 64'd5026996;
	localparam logic [63:0] SIN_C9 = 64'd172270;

	localparam int GRAD_W = 16;
	localparam int DOT_W  = 34;

	typedef logic [3:0][31:0]          corner_word_t;
	typedef logic signed [GRAD_W-1:0]  grad_t;
	typedef logic signed [DOT_W-1:0]   dot_t;
	typedef logic [16:0]               weight_t;

	function automatic logic [31:0] rot16(input logic [31:0] v);
		return {v[15:0], v[31:16]};
	endfunction

	// sin(pi/2 * f / 2^30) as Q14, f in [0, 2^30]; evaluated on constants only
	function automatic logic [14:0] quarter_sin(input logic [31:0] f);
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] r;
		logic [63:0] s;
		logic [63:0] q;
		t  = {32'd0, f};
		t2 = (t * t) >> 30;
		r  = SIN_C9;
		r  = SIN_C7 - ((t2 * r) >> 30);
		r  = SIN_C5 - ((t2 * r) >> 30);
		r  = SIN_C3 - ((t2 * r) >> 30);
		r  = SIN_C1 - ((t2 * r) >> 30);
		s  = (t * r) >> 30;
		q  = (s + 64'd32768) >> 16;
		if (q > 64'd16384) begin
			q = 64'd16384;
		end
		return q[14:0];
	endfunction

endpackage

// ----- hw/rtl/pgn_corner_hash.sv -----
// ----------------------------------------------------------------------------
// pgn_corner_hash
// Three-stage multiply / xor-rotate hash of the four cell corners.
// ----------------------------------------------------------------------------
module pgn_corner_hash (
	input  logic                 clk,
	input  logic                 en,
	input  logic [31:0]          x0,
	input  logic [31:0]          y0,
	output pgn_pkg::corner_word_t hash_s3
);
	import pgn_pkg::*;

	logic [1:0][31:0] ha_s1;
	logic [1:0][31:0] ya_s1;
	corner_word_t     hb_s2;
	corner_word_t     hb_c;
	corner_word_t     hc_c;
	logic [1:0][31:0] ha_s2;
	logic [1:0][31:0] xa;

	assign xa[0] = x0;
	assign xa[1] = x0 + 32'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			ha_s1[0] <= 32'(xa[0] * HASH_K1);
			ha_s1[1] <= 32'(xa[1] * HASH_K1);
			ya_s1[0] <= y0;
			ya_s1[1] <= y0 + 32'd1;
		end
	end

	// corner c: x index c[0], y index c[1]
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			hb_c[c] = 32'((ya_s1[c/2] ^ rot16(ha_s1[c%2])) * HASH_K2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hb_s2 <= hb_c;
			ha_s2 <= ha_s1;
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			hc_c[c] = 32'((ha_s2[c%2] ^ rot16(hb_s2[c])) * HASH_K3);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hash_s3 <= hc_c;
		end
	end

endmodule

// ----- hw/rtl/pgn_gradient.sv -----
// ----------------------------------------------------------------------------
// pgn_gradient
// Maps the top angle bits of a corner hash to a Q14 unit gradient.
// ----------------------------------------------------------------------------
module pgn_gradient #(
	parameter int ANGLE_BITS = 10
) (
	input  logic          clk,
	input  logic          en,
	input  logic [31:0]   hash,
	output pgn_pkg::grad_t gx_s4,
	output pgn_pkg::grad_t gy_s4
);
	import pgn_pkg::*;

	localparam int QN = 1 << (ANGLE_BITS - 2);
	localparam logic [ANGLE_BITS-2:0] QN_IDX = (ANGLE_BITS - 1)'(QN);

	logic [14:0]           sin_lut [QN+1];
	logic [ANGLE_BITS-3:0] k;
	logic [ANGLE_BITS-2:0] idx_s;
	logic [ANGLE_BITS-2:0] idx_c;
	logic [1:0]            quad;
	grad_t                 sf;
	grad_t                 cf;
	grad_t                 gx_c;
	grad_t                 gy_c;

	for (genvar gi = 0; gi <= QN; gi++) begin : g_lut
		assign sin_lut[gi] = quarter_sin(32'(gi) << (32 - ANGLE_BITS));
	end

	assign quad  = hash[31:30];
	assign k     = hash[29 -: (ANGLE_BITS - 2)];
	assign idx_s = {1'b0, k};
	assign idx_c = QN_IDX - idx_s;
	assign sf    = grad_t'({1'b0, sin_lut[idx_s]});
	assign cf    = grad_t'({1'b0, sin_lut[idx_c]});

	always_comb begin
		unique case (quad)
			2'd0: begin gx_c = cf;  gy_c = sf;  end
			2'd1: begin gx_c = -sf; gy_c = cf;  end
			2'd2: begin gx_c = -cf; gy_c = -sf; end
			default: begin gx_c = sf; gy_c = -cf; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s4 <= gx_c;
			gy_s4 <= gy_c;
		end
	end

endmodule

// ----- hw/rtl/pgn_fade.sv -----
// ----------------------------------------------------------------------------
// pgn_fade
// Five-stage smootherstep weight 6s^5 - 15s^4 + 10s^3 of a Q16 fraction.
// ----------------------------------------------------------------------------
module pgn_fade (
	input  logic            clk,
	input  logic            en,
	input  logic [15:0]     frac,
	output pgn_pkg::weight_t w_s5
);
	import pgn_pkg::*;

	logic [15:0] u_s1, u_s2, u_s3;
	logic [15:0] p2_s1;
	logic [15:0] p3_s2, p3_s3, p3_s4;
	logic [15:0] p4_s3, p4_s4;
	logic [15:0] p5_s4;
	logic [31:0] m1, m2, m3, m4;
	logic [19:0] pos, neg;
	logic [19:0] diff;
	weight_t     w_c;

	assign m1 = frac * frac;
	assign m2 = p2_s1 * u_s1;
	assign m3 = p3_s2 * u_s2;
	assign m4 = p4_s3 * u_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1  <= frac;
			p2_s1 <= m1[31:16];
			u_s2  <= u_s1;
			p3_s2 <= m2[31:16];
			u_s3  <= u_s2;
			p3_s3 <= p3_s2;
			p4_s3 <= m3[31:16];
			p3_s4 <= p3_s3;
			p4_s4 <= p4_s3;
			p5_s4 <= m4[31:16];
			w_s5  <= w_c;
		end
	end

	assign pos  = 20'(20'(p3_s4) * 20'd10) + 20'(20'(p5_s4) * 20'd6);
	assign neg  = 20'(20'(p4_s4) * 20'd15);
	assign diff = pos - neg;

	always_comb begin
		priority if (pos <= neg) begin
			w_c = '0;
		end else if (diff > 20'd65536) begin
			w_c = 17'd65536;
		end else begin
			w_c = diff[16:0];
		end
	end

endmodule

// ----- hw/rtl/perlin_gradient_noise_2d_unit.sv -----
// ----------------------------------------------------------------------------
// perlin_gradient_noise_2d_unit
// Throughput: one sample per cycle; the seven-stage pipeline advances as one
// and holds only while the output register carries a stalled beat.
// Reset: arst_n clears every stage valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
module perlin_gradient_noise_2d_unit #(
	parameter int FRAC_BITS  = 16,
	parameter int ANGLE_BITS = 10,
	parameter int OUT_BITS   = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic signed [31:0] x_coord,
	input  logic signed [31:0] y_coord,
	output logic        noise_valid,
	input  logic        noise_stall,
	output logic [15:0] noise_value
);
	import pgn_pkg::*;

	localparam logic [34:0] MAXV = 35'((64'd1 << OUT_BITS) - 64'd1);

	// Whole pipe moves together; it holds only behind a stalled output beat.
	logic en;
	assign en           = !noise_valid || !noise_stall;
	assign sample_stall = !en;

	// Stage valid bits travel with the data.
	logic [6:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[5:0], sample_valid};
		end
	end

	assign noise_valid = vld_q[6];

	// Split into integer cell (arithmetic shift = floor) and Q16 fraction.
	logic [31:0] x0, y0;
	logic [31:0] xf_w, yf_w;
	logic [15:0] fx, fy;

	assign x0   = 32'(x_coord >>> FRAC_BITS);
	assign y0   = 32'(y_coord >>> FRAC_BITS);
	assign xf_w = 32'(x_coord) << (32 - FRAC_BITS);
	assign yf_w = 32'(y_coord) << (32 - FRAC_BITS);
	assign fx   = xf_w[31:16];
	assign fy   = yf_w[31:16];

	// Carry the fractions alongside hash and gradient stages.
	logic [15:0] fx_s1, fx_s2, fx_s3, fx_s4;
	logic [15:0] fy_s1, fy_s2, fy_s3, fy_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			fx_s1 <= fx;
			fy_s1 <= fy;
			fx_s2 <= fx_s1;
			fy_s2 <= fy_s1;
			fx_s3 <= fx_s2;
			fy_s3 <= fy_s2;
			fx_s4 <= fx_s3;
			fy_s4 <= fy_s3;
		end
	end

	// Stages 1-3: corner hashes.
	corner_word_t hash_s3;

	pgn_corner_hash u_hash (
		.clk     (clk),
		.en      (en),
		.x0      (x0),
		.y0      (y0),
		.hash_s3 (hash_s3)
	);

	// Stage 4: gradient lookup per corner.
	grad_t gx_s4 [4];
	grad_t gy_s4 [4];

	for (genvar gc = 0; gc < 4; gc++) begin : g_corner
		pgn_gradient #(
			.ANGLE_BITS (ANGLE_BITS)
		) u_grad (
			.clk   (clk),
			.en    (en),
			.hash  (hash_s3[gc]),
			.gx_s4 (gx_s4[gc]),
			.gy_s4 (gy_s4[gc])
		);
	end

	// Stages 1-5: smootherstep weights.
	weight_t wx_s5, wy_s5, wy_s6;

	pgn_fade u_fade_x (
		.clk  (clk),
		.en   (en),
		.frac (fx),
		.w_s5 (wx_s5)
	);

	pgn_fade u_fade_y (
		.clk  (clk),
		.en   (en),
		.frac (fy),
		.w_s5 (wy_s5)
	);

	// Stage 5: dot each gradient with its corner offset. The far offset is
	// fraction - 1.0, which in 17 bits is the fraction under a set sign bit.
	logic signed [16:0] dx [4];
	logic signed [16:0] dy [4];
	dot_t               dot_c [4];
	dot_t               dot_s5 [4];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			dx[c]    = {c[0], fx_s4};
			dy[c]    = {c[1], fy_s4};
			dot_c[c] = DOT_W'(dx[c] * gx_s4[c]) + DOT_W'(dy[c] * gy_s4[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s5 <= dot_c;
		end
	end

	// a + floor((b - a) * w / 2^16)
	function automatic dot_t blend(input dot_t a, input dot_t b, input weight_t w);
		logic signed [DOT_W:0]    d;
		logic signed [DOT_W+18:0] p;
		d = (DOT_W+1)'(b) - (DOT_W+1)'(a);
		p = d * $signed({1'b0, w});
		return a + DOT_W'(p >>> 16);
	endfunction

	// Stage 6: blend along x.
	dot_t ix0_s6, ix1_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			ix0_s6 <= blend(dot_s5[0], dot_s5[1], wx_s5);
			ix1_s6 <= blend(dot_s5[2], dot_s5[3], wx_s5);
			wy_s6  <= wy_s5;
		end
	end

	// Stage 7: blend along y, shift into [0,1), saturate.
	dot_t               v_c;
	logic signed [34:0] m_c;
	logic [34:0]        r_c;
	logic [15:0]        out_c;

	assign v_c = blend(ix0_s6, ix1_s6, wy_s6);
	assign m_c = 35'(v_c) + 35'sd1073741824;
	assign r_c = 35'(m_c) >> (31 - OUT_BITS);

	always_comb begin
		priority if (m_c <= 0) begin
			out_c = '0;
		end else if (r_c > MAXV) begin
			out_c = MAXV[15:0];
		end else begin
			out_c = r_c[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			noise_value <= out_c;
		end
	end

endmodule

// ----- hw/rtl/pgn_checker.sv -----
// ----------------------------------------------------------------------------
// pgn_checker
// Port-level checks of the noise unit handshake, bound to the top level.
// ----------------------------------------------------------------------------
`include "perlin_gradient_noise_2d_unit_assert.svh"

module pgn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        sample_stall,
	input logic        noise_valid,
	input logic        noise_stall,
	input logic [15:0] noise_value
);

	// hold a stalled output beat
	`PGN_ASSERT_NEXT(a_out_hold, clk, arst_n, noise_valid && noise_stall, noise_valid)
	`PGN_ASSERT_NEXT(a_out_stable, clk, arst_n, noise_valid && noise_stall, $stable(noise_value))
	// input stalls only behind a stalled output beat
	`PGN_ASSERT_NOW(a_in_stall_cause, clk, arst_n, sample_stall, noise_valid && noise_stall)
	// an empty or draining output never blocks the input
	`PGN_ASSERT_NOW(a_in_free, clk, arst_n, !noise_valid || !noise_stall, !sample_stall)

endmodule

bind perlin_gradient_noise_2d_unit pgn_checker u_pgn_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_stall (sample_stall),
	.noise_valid  (noise_valid),
	.noise_stall  (noise_stall),
	.noise_value  (noise_value)
);
